@@ rtl/register_file_alu_executor_defines.svh @@
// Assertion macros shared by the register file executor modules.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef REGISTER_FILE_ALU_EXECUTOR_DEFINES_SVH
`define REGISTER_FILE_ALU_EXECUTOR_DEFINES_SVH

// Same-cycle implication.
`define RFAE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rfae_pkg.sv @@
// Shared types, constants and helpers for the register file executor.
// No dependencies.
package rfae_pkg;

  localparam int REG_COUNT_DEF = 26;
  localparam int WORD_W        = 32;
  localparam int IDX_W         = 5;
  localparam int OP_W          = 4;
  localparam int DIV_STEPS     = WORD_W;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 4'd0,
    OP_OUTPUT   = 4'd1,
    OP_MOVE     = 4'd2,
    OP_EXCHANGE = 4'd3,
    OP_ADD      = 4'd4,
    OP_SUB      = 4'd5,
    OP_MUL      = 4'd6,
    OP_DIV      = 4'd7,
    OP_MOD      = 4'd8,
    OP_AND      = 4'd9,
    OP_OR       = 4'd10,
    OP_XOR      = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_status_t;

  function automatic word_t negate_if(logic neg, word_t v);
    return neg ? -v : v;
  endfunction

endpackage

@@ rtl/register_file_alu_executor.sv @@
// Channel   Signals                                             Dir
// in        in_valid/in_stall, operation, dest_index,          sink
//           first_source, second_source, load_value
// out       out_valid/out_stall, out_value                      source
//
// Load, move, exchange and the combinational ALU ops pass ST_EXEC, ST_WRITE;
// output waits in ST_EXEC while the output register is still held; divide or
// modulo by zero writes nothing; divide/modulo run the 32-step divider first.
// Registers sit in a 2-read, 1-write memory with registered reads.
// Reset clears per-entry valid bits; an unwritten register reads as zero,
// so no clearing pass is needed. A held result does not block the next item unless it is an output.
// Depends on rfae_pkg, rfae_div and register_file_alu_executor_defines.svh.
`include "register_file_alu_executor_defines.svh"

module register_file_alu_executor #(
  parameter int REG_COUNT = rfae_pkg::REG_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rfae_pkg::OP_W-1:0]    operation,
  input  logic [rfae_pkg::IDX_W-1:0]   dest_index,
  input  logic [rfae_pkg::IDX_W-1:0]   first_source,
  input  logic [rfae_pkg::IDX_W-1:0]   second_source,
  input  rfae_pkg::word_t              load_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rfae_pkg::word_t              out_value
);
  import rfae_pkg::*;

  localparam int ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int EXT_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  function automatic logic in_range(logic [IDX_W-1:0] idx);
    return EXT_W'(idx) < EXT_W'(REG_COUNT);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(idx);
    return ext[ADDR_W-1:0];
  endfunction

  state_t            state;
  state_t            state_next;
  op_t               op_q;
  logic [IDX_W-1:0]  dest_q;
  logic [IDX_W-1:0]  src1_q;
  word_t             imm_q;

  word_t             mem [REG_COUNT];
  logic [REG_COUNT-1:0] reg_valid;
  word_t             rd_a;
  word_t             rd_b;
  logic              rd_a_ok;
  logic              rd_b_ok;
  word_t             opa;
  word_t             opb;
  logic [IDX_W-1:0]  rd_b_idx;

  logic              in_fire;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  word_t             wr_data;
  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr;

  word_t             alu_res;
  word_t             res;
  logic [IDX_W-1:0]  res_idx;
  logic              div_start;
  logic              out_load;
  logic              is_div;
  div_status_t       div_stat;

  assign in_fire  = in_valid && !in_stall;
  assign rd_b_idx = (op_t'(operation) == OP_EXCHANGE) ? dest_index : second_source;
  assign opa      = rd_a_ok ? rd_a : '0;
  assign opb      = rd_b_ok ? rd_b : '0;
  assign is_div   = (op_q == OP_DIV) || (op_q == OP_MOD);
  assign wr_ok    = wr_en && in_range(wr_idx);
  assign wr_addr  = to_addr(wr_idx);

  // Register file: two registered read ports, one write port.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_a    <= mem[to_addr(first_source)];
      rd_b    <= mem[to_addr(rd_b_idx)];
      rd_a_ok <= in_range(first_source) && reg_valid[to_addr(first_source)];
      rd_b_ok <= in_range(rd_b_idx) && reg_valid[to_addr(rd_b_idx)];
    end
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (wr_ok) begin
      reg_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q   <= op_t'(operation);
      dest_q <= dest_index;
      src1_q <= first_source;
      imm_q  <= load_value;
    end
  end

  always_comb begin
    unique case (op_q)
      OP_LOAD:     alu_res = imm_q;
      OP_MOVE:     alu_res = opa;
      OP_EXCHANGE: alu_res = opb;
      OP_ADD:      alu_res = opa + opb;
      OP_SUB:      alu_res = opa - opb;
      OP_MUL:      alu_res = opa * opb;
      OP_AND:      alu_res = opa & opb;
      OP_OR:       alu_res = opa | opb;
      OP_XOR:      alu_res = opa ^ opb;
      default:     alu_res = '0;
    endcase
  end

  // Exchange: old destination goes to first_source on the write cycle.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res     <= alu_res;
      res_idx <= (op_q == OP_EXCHANGE) ? src1_q : dest_q;
    end else if (state == ST_DIV && div_stat.done) begin
      res <= (op_q == OP_DIV) ? div_stat.quotient : div_stat.remainder;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (op_q)
          OP_OUTPUT: state_next = out_load ? ST_IDLE : ST_EXEC;
          OP_DIV, OP_MOD: state_next = (opb == '0) ? ST_IDLE : ST_DIV;
          OP_LOAD, OP_MOVE, OP_EXCHANGE, OP_ADD, OP_SUB, OP_MUL,
          OP_AND, OP_OR, OP_XOR: state_next = ST_WRITE;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = (state == ST_EXEC) && is_div && (opb != '0);
    out_load  = (state == ST_EXEC) && (op_q == OP_OUTPUT) && (!out_valid || !out_stall);
    wr_en     = 1'b0;
    wr_idx    = res_idx;
    wr_data   = res;
    unique case (state)
      ST_EXEC: begin
        if (op_q == OP_EXCHANGE) begin
          wr_en   = 1'b1;
          wr_idx  = dest_q;
          wr_data = opa;
        end
      end
      ST_WRITE: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= opa;
    end
  end

  rfae_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .status   (div_stat)
  );

  `RFAE_ASSERT_NEXT(a_accept_exec, in_fire, state == ST_EXEC, "accepted item not executed")
  `RFAE_ASSERT_NEXT(a_div_write, (state == ST_DIV) && div_stat.done, state == ST_WRITE,
                    "divide result not written back")
  `RFAE_ASSERT_NEXT(a_write_valid, wr_ok, reg_valid[$past(wr_addr)],
                    "written register not marked valid")

endmodule

@@ rtl/rfae_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rfae_pkg and register_file_alu_executor_defines.svh.
`include "register_file_alu_executor_defines.svh"

module rfae_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rfae_pkg::word_t     dividend,
  input  rfae_pkg::word_t     divisor,
  output rfae_pkg::div_status_t status
);
  import rfae_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] mag_b;
  logic              neg_q;
  logic              neg_r;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              last_step;

  assign shifted   = {rem, quo[WORD_W-1]};
  assign diff      = shifted - {1'b0, mag_b};
  assign last_step = (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring step on magnitudes; signs fixed up at the output.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= negate_if(dividend[WORD_W-1], dividend);
      mag_b <= negate_if(divisor[WORD_W-1], divisor);
      neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      neg_r <= dividend[WORD_W-1];
    end else if (busy) begin
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign status.done      = done;
  assign status.quotient  = negate_if(neg_q, quo);
  assign status.remainder = negate_if(neg_r, rem);

  `RFAE_ASSERT_NEXT(a_start_busy, start, busy, "divider not busy after start")
  `RFAE_ASSERT_NEXT(a_last_done, busy && last_step && !start, done && !busy,
                    "divider did not finish after last step")
  `RFAE_ASSERT_SAME(a_done_idle, done, !busy, "divider busy while reporting done")

endmodule
